FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: rtl/ufc_pkg.sv
// types, constants and crc helper for the frame checker
package ufc_pkg;

    localparam int unsigned MAX_FRAME_DEF = 8192;
    localparam int unsigned MIN_FRAME     = 12;
    localparam int unsigned HDR_BYTES     = 6;
    localparam int unsigned POS_COMMAND   = 6;
    localparam int unsigned POS_KIND      = 7;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [47:0] HDR_RESET  = 48'h585858434944;
    localparam logic [7:0]  CMD_FWD    = 8'd6;
    localparam logic [7:0]  KIND_FWD   = 8'd1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SIZE   = 3'd1,
        ST_HEADER = 3'd2,
        ST_LENGTH = 3'd3,
        ST_CRC    = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  command;
        logic [7:0]  kind;
        logic        forward;
        logic [13:0] frame_length;
    } t_out_item;

    // handshake between the input stage and the frame core
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

    // crc-16/modbus update by one byte, bitwise reflected form
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/ufc_in_reg.sv
// input register stage for received bytes
module ufc_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ufc_pkg::t_in_item   i_in,
    input  logic                i_advance,
    output logic                o_in_stall,
    output ufc_pkg::t_stage_ctl o_ctl,
    output ufc_pkg::t_in_item   o_item
);
    import ufc_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_load;

    // take a new item whenever the stage is empty or its item moves on
    assign w_load     = !r_valid || i_advance;
    assign o_in_stall = !w_load;
    assign n_valid    = w_load ? i_in_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_item <= i_in;
        end
    end

    assign o_ctl.valid   = r_valid;
    assign o_ctl.advance = i_advance;
    assign o_item        = r_item;

endmodule

FILE: rtl/ufc_frame_core.sv
// per-frame state: header compare, counters, crc and verdict
`include "assert_macros.svh"
module ufc_frame_core #(
    parameter int unsigned MAX_FRAME = ufc_pkg::MAX_FRAME_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ufc_pkg::t_stage_ctl i_ctl,
    input  ufc_pkg::t_in_item   i_item,
    input  logic [47:0]         i_header,
    output logic                o_res_valid,
    output ufc_pkg::t_out_item  o_res
);
    import ufc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [15:0]   r_crc_now, n_crc_now;
    logic [15:0]   r_crc_lag_one, n_crc_lag_one;
    logic [31:0]   r_recent, n_recent;
    logic          r_header_bad, n_header_bad;
    logic [7:0]    r_command, n_command;
    logic [7:0]    r_kind, n_kind;
    logic          r_overflow, n_overflow;

    logic [7:0]    w_want;
    logic [CW-1:0] w_count;
    logic          w_overflow;
    logic          w_header_bad;
    logic [7:0]    w_command;
    logic [7:0]    w_kind;
    logic [31:0]   w_recent;
    t_status       w_status;
    logic          w_last;

    assign w_last = i_ctl.advance && i_item.last_byte;

    // expected header byte for the current position
    always_comb begin
        case (r_byte_count[2:0])
            3'd0:    w_want = i_header[47:40];
            3'd1:    w_want = i_header[39:32];
            3'd2:    w_want = i_header[31:24];
            3'd3:    w_want = i_header[23:16];
            3'd4:    w_want = i_header[15:8];
            3'd5:    w_want = i_header[7:0];
            default: w_want = 8'h00;
        endcase
    end

    always_comb begin
        w_header_bad = r_header_bad ||
                       ((r_byte_count < CW'(HDR_BYTES)) && (w_want != i_item.data_byte));
        w_command    = (r_byte_count == CW'(POS_COMMAND)) ? i_item.data_byte : r_command;
        w_kind       = (r_byte_count == CW'(POS_KIND)) ? i_item.data_byte : r_kind;
        // count saturates at the maximum, further bytes flag an overflow
        if (r_byte_count >= CW'(MAX_FRAME)) begin
            w_overflow = 1'b1;
            w_count    = r_byte_count;
        end else begin
            w_overflow = r_overflow;
            w_count    = r_byte_count + 1'b1;
        end
        w_recent = {r_recent[23:0], i_item.data_byte};

        // crc two bytes back is the current lag-one value
        if (w_overflow || (w_count < CW'(MIN_FRAME))) begin
            w_status = ST_SIZE;
        end else if (w_header_bad) begin
            w_status = ST_HEADER;
        end else if (w_recent[31:16] != 16'(w_count)) begin
            w_status = ST_LENGTH;
        end else if ((w_recent[15:8] != r_crc_lag_one[7:0]) ||
                     (w_recent[7:0] != r_crc_lag_one[15:8])) begin
            w_status = ST_CRC;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_byte_count  = r_byte_count;
        n_crc_now     = r_crc_now;
        n_crc_lag_one = r_crc_lag_one;
        n_recent      = r_recent;
        n_header_bad  = r_header_bad;
        n_command     = r_command;
        n_kind        = r_kind;
        n_overflow    = r_overflow;
        if (w_last) begin
            n_byte_count  = '0;
            n_crc_now     = CRC_INIT;
            n_crc_lag_one = CRC_INIT;
            n_recent      = '0;
            n_header_bad  = 1'b0;
            n_command     = '0;
            n_kind        = '0;
            n_overflow    = 1'b0;
        end else if (i_ctl.advance) begin
            n_byte_count  = w_count;
            n_crc_now     = crc16_byte(r_crc_now, i_item.data_byte);
            n_crc_lag_one = r_crc_now;
            n_recent      = w_recent;
            n_header_bad  = w_header_bad;
            n_command     = w_command;
            n_kind        = w_kind;
            n_overflow    = w_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_crc_now     <= CRC_INIT;
            r_crc_lag_one <= CRC_INIT;
            r_recent      <= '0;
            r_header_bad  <= 1'b0;
            r_command     <= '0;
            r_kind        <= '0;
            r_overflow    <= 1'b0;
        end else begin
            r_byte_count  <= n_byte_count;
            r_crc_now     <= n_crc_now;
            r_crc_lag_one <= n_crc_lag_one;
            r_recent      <= n_recent;
            r_header_bad  <= n_header_bad;
            r_command     <= n_command;
            r_kind        <= n_kind;
            r_overflow    <= n_overflow;
        end
    end

    assign o_res_valid        = w_last;
    assign o_res.status       = w_status;
    assign o_res.command      = w_command;
    assign o_res.kind         = w_kind;
    assign o_res.forward      = (w_status == ST_OK) && (w_kind == KIND_FWD) &&
                                (w_command == CMD_FWD);
    assign o_res.frame_length = 14'(w_count);

    `ASSERT_AT(a_clear_after_last, i_clk, i_rst_n, w_last |=> (r_byte_count == '0) && (r_crc_now == CRC_INIT) && !r_overflow)
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_byte_count > CW'(MAX_FRAME))
    `ASSERT_AT(a_overflow_at_max, i_clk, i_rst_n, r_overflow |-> (r_byte_count == CW'(MAX_FRAME)))
    `ASSERT_NEVER(a_advance_without_item, i_clk, i_rst_n, i_ctl.advance && !i_ctl.valid)

endmodule

FILE: rtl/ufc_out_reg.sv
// result register holding one verdict until it is taken
module ufc_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ufc_pkg::t_out_item i_res,
    input  logic               i_out_stall,
    output logic               o_free,
    output logic               o_out_valid,
    output ufc_pkg::t_out_item o_out
);
    import ufc_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_res;

    assign o_free  = !r_valid || !i_out_stall;
    assign n_valid = i_load ? 1'b1 : (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_res;

endmodule

FILE: rtl/udp_frame_checker.sv
// top level of the received datagram checker
`include "assert_macros.svh"
// udp_frame_checker takes a datagram one byte per item, with last_byte set on
// the final byte, and gives one verdict item per frame: status (0 ok, 1 bad
// size, 2 bad header, 3 bad length field, 4 bad crc; the lowest fault wins),
// the command and kind bytes at offsets 6 and 7, a forward flag (ok, kind 1,
// command 6) and the byte count saturated at MAX_FRAME. the header is checked
// against the 48-bit configured pattern (first byte in the top bits), the
// big-endian field four bytes before the end against the frame length, and
// the last two bytes against crc-16/modbus of everything before them, low
// byte first. throughput is one byte per cycle outside the input stall below: the
// crc update is an unrolled 8-bit step between the input register and the frame
// state, so a byte enters every cycle. a verdict is loaded into the result
// register from the final byte held in the input register. the input side stalls
// only when a final byte finds the result register full and stalled. the header
// register should be written between frames; its write port is always ready.
module udp_frame_checker #(
    parameter int unsigned MAX_FRAME = ufc_pkg::MAX_FRAME_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte items in
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ufc_pkg::t_in_item  i_in,
    // verdict items out
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ufc_pkg::t_out_item o_out,
    // header pattern write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [47:0]        i_cfg_data
);
    import ufc_pkg::*;

    // configured header, reset to the default six bytes
    logic [47:0] r_header;

    t_stage_ctl  w_ctl;
    t_in_item    w_item;
    logic        w_advance;
    logic        w_out_free;
    logic        w_res_valid;
    t_out_item   w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HDR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_header <= i_cfg_data;
        end
    end

    // a held byte moves on unless it closes a frame and the verdict slot is busy
    assign w_advance = w_ctl.valid && (!w_item.last_byte || w_out_free);

    ufc_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_advance  (w_advance),
        .o_in_stall (o_in_stall),
        .o_ctl      (w_ctl),
        .o_item     (w_item)
    );

    // frame state and verdict logic
    ufc_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_item      (w_item),
        .i_header    (r_header),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register parts the two handshakes
    ufc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_valid),
        .i_res       (w_res),
        .i_out_stall (i_out_stall),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // a verdict is only produced when the result register can take it
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_res_valid && o_out_valid && i_out_stall)
    // the input side only waits on a final byte blocked at the output
    `ASSERT_AT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> w_ctl.valid && w_item.last_byte && o_out_valid && i_out_stall)
    // a forwarded frame is always a good one
    `ASSERT_AT(a_forward_ok, i_clk, i_rst_n, w_res_valid && w_res.forward |-> w_res.status == ST_OK)

endmodule

FILE: verif/tb_udp_frame_checker.sv
`timescale 1ns / 100ps
// self-checking testbench for the datagram checker, with frame builder, verdict predictor and drivers
module tb_udp_frame_checker;
    import ufc_pkg::*;

    localparam int unsigned FRAME_CAP   = MAX_FRAME_DEF;
    localparam int unsigned IDLE_PCT    = 27;
    // settle pause once every verdict is in, a little margin on top
    localparam int unsigned SETTLE_CYC  = 4;
    // longest legal quiet spell is a short random stall run or the settle pause
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PHASE_BYTES = 110;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned CALM_PHASE  = 3;

    // how a generated frame is spoilt, if at all
    typedef enum int {
        FR_GOOD,
        FR_BAD_HDR,
        FR_BAD_LEN,
        FR_BAD_CRC,
        FR_SHORT,
        FR_NOISE
    } t_flaw;

    // one byte of crc-16/modbus, reflected, lsb first
    function automatic logic [15:0] modbus_step(logic [15:0] acc, logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
        return r;
    endfunction

    // mirrors the frame state and queues the verdict each final byte should give
    class verdict_board;
        logic [47:0] header;
        int unsigned cap;
        int unsigned count;
        logic [15:0] crc_run;
        logic [15:0] crc_lag1;
        logic [15:0] crc_lag2;
        logic [31:0] tail;
        bit          hdr_bad;
        bit          overflow;
        logic [7:0]  cmd_byte;
        logic [7:0]  kind_byte;
        t_out_item   verdicts[$];
        int          errors;
        int          frames;
        int          forwarded;
        int          per_status[5];

        function new(int unsigned cap_bytes);
            cap       = cap_bytes;
            header    = HDR_RESET;
            errors    = 0;
            frames    = 0;
            forwarded = 0;
            foreach (per_status[i]) per_status[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            count     = 0;
            crc_run   = CRC_INIT;
            crc_lag1  = CRC_INIT;
            crc_lag2  = CRC_INIT;
            tail      = '0;
            hdr_bad   = 1'b0;
            overflow  = 1'b0;
            cmd_byte  = '0;
            kind_byte = '0;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int unsigned pos;
            t_status     st;
            t_out_item   v;
            pos = count;
            if (pos < HDR_BYTES) begin
                if (header[8 * (HDR_BYTES - 1 - pos) +: 8] != b) hdr_bad = 1'b1;
            end
            if (pos == POS_COMMAND) cmd_byte = b;
            if (pos == POS_KIND) kind_byte = b;
            // count saturates, anything beyond the cap marks the frame oversize
            if (count >= cap) overflow = 1'b1;
            else count++;
            crc_lag2 = crc_lag1;
            crc_lag1 = crc_run;
            crc_run  = modbus_step(crc_run, b);
            tail     = {tail[23:0], b};
            if (!last) return;
            // lowest fault code wins
            if (overflow || count < MIN_FRAME) st = ST_SIZE;
            else if (hdr_bad) st = ST_HEADER;
            else if (32'(tail[31:16]) != count) st = ST_LENGTH;
            else if (tail[15:8] != crc_lag2[7:0] || tail[7:0] != crc_lag2[15:8]) st = ST_CRC;
            else st = ST_OK;
            v.status       = st;
            v.command      = cmd_byte;
            v.kind         = kind_byte;
            v.forward      = (st == ST_OK && kind_byte == KIND_FWD && cmd_byte == CMD_FWD);
            v.frame_length = 14'(count);
            verdicts.push_back(v);
            clear_frame();
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            errors++;
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (verdicts.size() == 0) begin
                report_mismatch("verdict with none outstanding", 32'(got), 0);
                return;
            end
            want = verdicts.pop_front();
            frames++;
            per_status[want.status]++;
            if (want.forward) forwarded++;
            if (got.status != want.status)
                report_mismatch("status", got.status, want.status);
            if (got.command != want.command)
                report_mismatch("command", got.command, want.command);
            if (got.kind != want.kind)
                report_mismatch("kind", got.kind, want.kind);
            if (got.forward != want.forward)
                report_mismatch("forward", got.forward, want.forward);
            if (got.frame_length != want.frame_length)
                report_mismatch("frame length", got.frame_length, want.frame_length);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [47:0] i_cfg_data;

    // high while neither side inserts idle cycles
    logic        calm = 1'b0;
    verdict_board board;
    logic [7:0]  frame_buf[$];
    int unsigned bytes_sent = 0;
    int unsigned quiet_cycles = 0;

    udp_frame_checker #(
        .MAX_FRAME(FRAME_CAP)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // verdict side back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // every accepted verdict is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out);
    end

    // ends a run that has stopped making progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("udp_frame_checker verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // builds a frame into frame_buf against the header currently configured
    function automatic void fill_frame(int unsigned n, logic [7:0] cmd, logic [7:0] kind,
                                       t_flaw flaw);
        int unsigned full;
        int unsigned spot;
        logic [15:0] crc;
        frame_buf.delete();
        if (flaw == FR_NOISE) begin
            repeat (n) frame_buf.push_back(8'($urandom));
            return;
        end
        full = (n < MIN_FRAME) ? MIN_FRAME : n;
        for (int i = 0; i < HDR_BYTES; i++)
            frame_buf.push_back(board.header[8 * (HDR_BYTES - 1 - i) +: 8]);
        frame_buf.push_back(cmd);
        frame_buf.push_back(kind);
        repeat (full - MIN_FRAME) frame_buf.push_back(8'($urandom));
        // big-endian length, then crc low byte first
        frame_buf.push_back(8'(full >> 8));
        frame_buf.push_back(8'(full));
        crc = CRC_INIT;
        foreach (frame_buf[i]) crc = modbus_step(crc, frame_buf[i]);
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
        spot = full;
        case (flaw)
            FR_BAD_HDR: spot = $urandom_range(HDR_BYTES - 1);
            FR_BAD_LEN: spot = full - 4 + $urandom_range(1);
            FR_BAD_CRC: spot = full - 2 + $urandom_range(1);
            FR_SHORT: begin
                while (frame_buf.size() > n) void'(frame_buf.pop_back());
            end
            default: ;
        endcase
        // a single flipped bit always spoils the chosen field
        if (spot < full) frame_buf[spot] ^= 8'(1 << $urandom_range(7));
    endfunction

    task automatic push_byte(logic [7:0] b, logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{data_byte: b, last_byte: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) push_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // sender holds off until every verdict is in and the pipeline has emptied
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic load_header(logic [47:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.header = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly well-formed frames with random content, the rest spoilt or noise
    task automatic random_frame();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  cmd;
        logic [7:0]  kind;
        t_flaw       flaw;
        pick = $urandom_range(99);
        n    = MIN_FRAME + (($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(24));
        if ($urandom_range(2) == 0) begin
            cmd  = CMD_FWD;
            kind = KIND_FWD;
        end else begin
            cmd  = ($urandom_range(3) == 0) ? CMD_FWD : 8'($urandom);
            kind = ($urandom_range(3) == 0) ? KIND_FWD : 8'($urandom);
        end
        if (pick < 64) begin
            flaw = FR_GOOD;
        end else if (pick < 71) begin
            flaw = FR_BAD_HDR;
        end else if (pick < 78) begin
            flaw = FR_BAD_LEN;
        end else if (pick < 85) begin
            flaw = FR_BAD_CRC;
        end else if (pick < 93) begin
            flaw = FR_SHORT;
            n    = $urandom_range(MIN_FRAME - 1, 1);
        end else begin
            flaw = FR_NOISE;
            n    = $urandom_range(40, 1);
        end
        fill_frame(n, cmd, kind, flaw);
        send_frame();
    endtask

    initial begin
        logic [63:0] wide;
        int unsigned target;
        board = new(FRAME_CAP);
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames against the reset header
        fill_frame(MIN_FRAME, CMD_FWD, KIND_FWD, FR_GOOD);
        send_frame();
        fill_frame(MIN_FRAME + 3, CMD_FWD, 8'd2, FR_GOOD);
        send_frame();
        fill_frame(MIN_FRAME + 1, 8'd5, KIND_FWD, FR_GOOD);
        send_frame();
        fill_frame(MIN_FRAME + 2, 8'hFF, 8'h00, FR_GOOD);
        send_frame();
        // short frames: nothing captured, command only, one byte shy
        fill_frame(1, CMD_FWD, KIND_FWD, FR_SHORT);
        send_frame();
        fill_frame(POS_COMMAND + 1, CMD_FWD, KIND_FWD, FR_SHORT);
        send_frame();
        fill_frame(MIN_FRAME - 1, CMD_FWD, KIND_FWD, FR_SHORT);
        send_frame();
        fill_frame(MIN_FRAME, CMD_FWD, KIND_FWD, FR_BAD_HDR);
        send_frame();
        fill_frame(MIN_FRAME + 4, CMD_FWD, KIND_FWD, FR_BAD_LEN);
        send_frame();
        fill_frame(MIN_FRAME + 4, CMD_FWD, KIND_FWD, FR_BAD_CRC);
        send_frame();
        // several faults at once, the lowest code must win
        fill_frame(MIN_FRAME, CMD_FWD, KIND_FWD, FR_BAD_HDR);
        frame_buf[frame_buf.size() - 1] ^= 8'h80;
        send_frame();
        fill_frame(9, CMD_FWD, KIND_FWD, FR_SHORT);
        frame_buf[0] ^= 8'h01;
        send_frame();
        drain();

        // random phases, each under its own header, one with no idling at all
        for (int ph = 0; ph < PHASES; ph++) begin
            wide = {$urandom, $urandom};
            case (ph)
                0:          load_header('0);
                1:          load_header('1);
                PHASES - 1: load_header(HDR_RESET);
                default:    load_header(wide[47:0]);
            endcase
            calm   <= (ph == CALM_PHASE);
            target  = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) random_frame();
        end

        calm       <= 1'b0;
        i_in_valid <= 1'b0;
        for (int k = 0; k < 400 && board.verdicts.size() != 0; k++) @(posedge i_clk);
        repeat (2 * SETTLE_CYC) @(posedge i_clk);
        if (board.verdicts.size() != 0)
            board.report_mismatch("verdicts never delivered", 0, board.verdicts.size());

        $display("checked %0d frames from %0d bytes under %0d header settings, %0d forwarded",
                 board.frames, bytes_sent, PHASES + 1, board.forwarded);
        $display("verdicts seen: ok %0d, size %0d, header %0d, length %0d, crc %0d",
                 board.per_status[ST_OK], board.per_status[ST_SIZE],
                 board.per_status[ST_HEADER], board.per_status[ST_LENGTH],
                 board.per_status[ST_CRC]);
        if (board.errors == 0) begin
            $display("udp_frame_checker verification clean");
        end else begin
            $display("udp_frame_checker verification failed");
        end
        $finish;
    end

endmodule
